FILE: rtl/msum_pkg.sv
`default_nettype none

package msum_pkg;

	// Field widths fixed by the interface.
	localparam int VALUE_W   = 16;
	localparam int CFG_W     = 7;
	localparam int MAX_SUM_W = 27;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	// Register indexes of the configuration channel.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	// Reset value of both size registers.
	localparam int SIZE_RST = 64;

	typedef enum logic {
		ST_LOAD,
		ST_SEARCH
	} top_state_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Control that travels with each element issued to the band datapath.
	typedef struct packed {
		logic valid;      // an element is issued this cycle
		logic first_row;  // bottom row equals top row: column sums start at zero
		logic first_col;  // first column of a band row: running sum starts at zero
		logic last;       // final element of the whole search
	} band_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/msum_matrix.sv
`default_nettype none

// Element store: one write port for loading, one registered read port for the search.
module msum_matrix #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  wire                                   clk,
	input  wire                                   wr_en,
	input  wire  [ADDR_W-1:0]                     wr_addr,
	input  wire  signed [msum_pkg::VALUE_W-1:0]   wr_data,
	input  wire                                   rd_en,
	input  wire  [ADDR_W-1:0]                     rd_addr,
	output logic signed [msum_pkg::VALUE_W-1:0]   rd_data
);

	logic signed [msum_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/msum_seq.sv
`default_nettype none

// Walks top row, bottom row and column, issuing one element address per cycle.
module msum_seq #(
	parameter int ROW_W  = 7,
	parameter int COL_W  = 7,
	parameter int RIDX_W = 6,
	parameter int CIDX_W = 6,
	parameter int ADDR_W = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [ROW_W-1:0]             rows,
	input  wire  [COL_W-1:0]             cols,
	output msum_pkg::band_ctl_t          issue,
	output logic [CIDX_W-1:0]            col,
	output logic [ADDR_W-1:0]            addr
);

	msum_pkg::seq_state_t state_q, state_d;

	logic [RIDX_W-1:0] top_q, bot_q;
	logic [CIDX_W-1:0] k_q;
	logic [ADDR_W-1:0] addr_q, top_base_q;
	logic [ROW_W-1:0]  rows_m1;
	logic [COL_W-1:0]  cols_m1;
	logic              k_last, bot_last, top_last;
	logic [ADDR_W:0]   next_base;

	assign rows_m1  = rows - 1'b1;
	assign cols_m1  = cols - 1'b1;
	assign k_last   = (COL_W'(k_q) == cols_m1);
	assign bot_last = (ROW_W'(bot_q) == rows_m1);
	assign top_last = (ROW_W'(top_q) == rows_m1);
	assign next_base = {1'b0, top_base_q} + (ADDR_W+1)'(cols);

	always_comb begin
		state_d = state_q;
		case (state_q)
			msum_pkg::SEQ_IDLE: begin
				if (start) begin
					state_d = msum_pkg::SEQ_RUN;
				end
			end
			msum_pkg::SEQ_RUN: begin
				if (top_last && k_last) begin
					state_d = msum_pkg::SEQ_IDLE;
				end
			end
			default: state_d = msum_pkg::SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msum_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Rows are contiguous, so the address simply counts up within a band and
	// jumps to the next top row when a band finishes.
	always_ff @(posedge clk) begin
		if (start) begin
			top_q      <= '0;
			bot_q      <= '0;
			k_q        <= '0;
			addr_q     <= '0;
			top_base_q <= '0;
		end else if (state_q == msum_pkg::SEQ_RUN) begin
			if (!k_last) begin
				k_q    <= k_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end else if (!bot_last) begin
				k_q    <= '0;
				bot_q  <= bot_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end else begin
				k_q        <= '0;
				top_q      <= top_q + 1'b1;
				bot_q      <= top_q + 1'b1;
				top_base_q <= next_base[ADDR_W-1:0];
				addr_q     <= next_base[ADDR_W-1:0];
			end
		end
	end

	assign issue.valid     = (state_q == msum_pkg::SEQ_RUN);
	assign issue.first_row = (bot_q == top_q);
	assign issue.first_col = (k_q == '0);
	assign issue.last      = top_last && k_last;
	assign col  = k_q;
	assign addr = addr_q;

endmodule

`default_nettype wire

FILE: rtl/msum_band.sv
`default_nettype none

// Column-sum memory with read-modify-write, then the Kadane scan and the best tracker.
module msum_band #(
	parameter int MAX_COLS = 64,
	parameter int CIDX_W   = 6,
	parameter int CS_W     = 23,
	parameter int SUM_W    = 29
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  msum_pkg::band_ctl_t                  issue,
	input  wire  [CIDX_W-1:0]                    col,
	input  wire  signed [msum_pkg::VALUE_W-1:0]  elem,
	output logic                                 done,
	output logic signed [SUM_W-1:0]              best
);

	logic signed [CS_W-1:0] cs_mem [MAX_COLS];

	msum_pkg::band_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [CIDX_W-1:0]      col_s1;
	logic signed [CS_W-1:0] cs_rd_s1, fwd_data_s1, cs_s2;
	logic                   fwd_s1;
	logic signed [CS_W-1:0] cs_old, cs_new;
	logic signed [SUM_W-1:0] run_q, run_base, run_sum, run_s3, best_q;
	logic                   done_s4;

	// A write in stage one and a read of the same column in the same cycle
	// happen when a band row has one column; the new sum is forwarded.
	assign cs_old = ctl_s1.first_row ? '0 : (fwd_s1 ? fwd_data_s1 : cs_rd_s1);
	assign cs_new = cs_old + CS_W'(elem);

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			cs_mem[col_s1] <= cs_new;
		end
		if (issue.valid) begin
			cs_rd_s1 <= cs_mem[col];
		end
		fwd_s1      <= ctl_s1.valid && (col_s1 == col);
		fwd_data_s1 <= cs_new;
		col_s1      <= col;
		cs_s2       <= cs_new;
	end

	assign run_base = ctl_s2.first_col ? '0 : run_q;
	assign run_sum  = run_base + SUM_W'(cs_s2);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			run_q  <= run_sum[SUM_W-1] ? '0 : run_sum;
			run_s3 <= run_sum[SUM_W-1] ? '0 : run_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			done_s4 <= 1'b0;
			best_q  <= '0;
		end else begin
			ctl_s1  <= issue;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			done_s4 <= ctl_s3.valid && ctl_s3.last;
			if (start) begin
				best_q <= '0;
			end else if (ctl_s3.valid && (run_s3 > best_q)) begin
				best_q <= run_s3;
			end
		end
	end

	assign done = done_s4;
	assign best = best_q;

endmodule

`default_nettype wire

FILE: rtl/max_submatrix_sum_top.sv
`default_nettype none

// Largest sum over any contiguous rectangle of a signed matrix.
//
// Elements arrive on the s_ stream, one 16-bit two's complement value per
// transaction, in row-major order. The matrix size comes from the cfg channel:
// index 0 sets the row count, index 1 the column count; zero reads as one and a
// value above the maximum saturates. Any size write discards a partial load.
// The element that completes the matrix starts the search, during which
// s_tready is low. The search issues one element per cycle from the element
// memory, a rate set by the single read port of that memory and of the
// column-sum memory; the result reaches m_ through the band pipeline, the best
// register and the result register. One result per matrix.
// The result register separates the two sides: while a result waits for
// m_tready, the next matrix keeps loading, and only its final element is held
// off until the result has been taken. Reset clears the load count and the
// control state and sets both sizes to 64 (or to the maximum, if smaller); no
// memory clearing pass is needed. cfg_ready is always high.
module max_submatrix_sum_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// Configuration write channel.
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire  [msum_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  wire  [msum_pkg::CFG_W-1:0]                cfg_data,
	// Element stream.
	input  wire                                       s_tvalid,
	output logic                                      s_tready,
	input  wire  [msum_pkg::IN_TDATA_W-1:0]           s_tdata,  // [15:0] value
	// Result stream.
	output logic                                      m_tvalid,
	input  wire                                       m_tready,
	output logic [msum_pkg::OUT_TDATA_W-1:0]          m_tdata   // [26:0] max_sum, [31:27] zero
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W  = $clog2(MAX_COLS + 1);
	localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CS_W   = msum_pkg::VALUE_W + 1 + $clog2(MAX_ROWS);
	localparam int SUM_W  = msum_pkg::VALUE_W + 1 + $clog2(DEPTH);
	localparam int ROWS_RST =
		(MAX_ROWS < msum_pkg::SIZE_RST) ? MAX_ROWS : msum_pkg::SIZE_RST;
	localparam int COLS_RST =
		(MAX_COLS < msum_pkg::SIZE_RST) ? MAX_COLS : msum_pkg::SIZE_RST;

	msum_pkg::top_state_t state_q, state_d;

	logic [ROW_W-1:0] rows_q;
	logic [COL_W-1:0] cols_q;
	logic [CNT_W-1:0] load_count_q, load_next;
	logic [CNT_W-1:0] total;
	logic             last_elem, in_acc, cfg_acc, start;
	logic             out_valid_q;
	logic [msum_pkg::MAX_SUM_W-1:0] out_data_q;

	msum_pkg::band_ctl_t issue;
	logic [CIDX_W-1:0]   col;
	logic [ADDR_W-1:0]   rd_addr;
	logic signed [msum_pkg::VALUE_W-1:0] elem;
	logic                band_done;
	logic signed [SUM_W-1:0] best;
	logic [SUM_W+msum_pkg::MAX_SUM_W-1:0] best_ext;

	// Size registers, clamped as they are written.
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROW_W'(ROWS_RST);
			cols_q <= COL_W'(COLS_RST);
		end else if (cfg_acc) begin
			case (cfg_index)
				msum_pkg::REG_ROW_COUNT: begin
					if (cfg_data == '0) begin
						rows_q <= ROW_W'(1);
					end else if (32'(cfg_data) > MAX_ROWS) begin
						rows_q <= ROW_W'(MAX_ROWS);
					end else begin
						rows_q <= ROW_W'(cfg_data);
					end
				end
				msum_pkg::REG_COL_COUNT: begin
					if (cfg_data == '0) begin
						cols_q <= COL_W'(1);
					end else if (32'(cfg_data) > MAX_COLS) begin
						cols_q <= COL_W'(MAX_COLS);
					end else begin
						cols_q <= COL_W'(cfg_data);
					end
				end
				default: ;
			endcase
		end
	end

	// Load counting. The completing element is held off while a result waits.
	assign total     = CNT_W'(rows_q * cols_q);
	assign load_next = load_count_q + 1'b1;
	assign last_elem = (load_next == total);
	assign s_tready  = (state_q == msum_pkg::ST_LOAD) && !(out_valid_q && last_elem);
	assign in_acc    = s_tvalid && s_tready;
	assign start     = in_acc && last_elem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (cfg_acc || start) begin
			load_count_q <= '0;
		end else if (in_acc) begin
			load_count_q <= load_next;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			msum_pkg::ST_LOAD: begin
				if (start) begin
					state_d = msum_pkg::ST_SEARCH;
				end
			end
			msum_pkg::ST_SEARCH: begin
				if (band_done) begin
					state_d = msum_pkg::ST_LOAD;
				end
			end
			default: state_d = msum_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msum_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	msum_matrix #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_matrix (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (load_count_q[ADDR_W-1:0]),
		.wr_data (s_tdata[msum_pkg::VALUE_W-1:0]),
		.rd_en   (issue.valid),
		.rd_addr (rd_addr),
		.rd_data (elem)
	);

	msum_seq #(
		.ROW_W  (ROW_W),
		.COL_W  (COL_W),
		.RIDX_W (RIDX_W),
		.CIDX_W (CIDX_W),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.rows   (rows_q),
		.cols   (cols_q),
		.issue  (issue),
		.col    (col),
		.addr   (rd_addr)
	);

	msum_band #(
		.MAX_COLS (MAX_COLS),
		.CIDX_W   (CIDX_W),
		.CS_W     (CS_W),
		.SUM_W    (SUM_W)
	) u_band (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.issue  (issue),
		.col    (col),
		.elem   (elem),
		.done   (band_done),
		.best   (best)
	);

	// The best sum is never negative, so zero extension is exact before the
	// result is cut to its field width.
	assign best_ext = {{msum_pkg::MAX_SUM_W{1'b0}}, best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (band_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (band_done) begin
			out_data_q <= best_ext[msum_pkg::MAX_SUM_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(msum_pkg::OUT_TDATA_W - msum_pkg::MAX_SUM_W){1'b0}}, out_data_q};

	// A finished search must find the result register empty.
	assert property (@(posedge clk) disable iff (!arst_n) band_done |-> !out_valid_q)
		else $error("search result would overwrite a pending result");

	// The sequencer only issues element reads during a search.
	assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> (state_q == msum_pkg::ST_SEARCH))
		else $error("element issued outside a search");

	// The load count never reaches the matrix size.
	assert property (@(posedge clk) disable iff (!arst_n) load_count_q < total)
		else $error("load count out of range");

	// A search start is followed on the next cycle by the search state and the first element issue.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == msum_pkg::ST_SEARCH) && issue.valid)
		else $error("search did not start");

endmodule

`default_nettype wire
